[hw/rtl/cshs_pkg.sv]
package cshs_pkg;

  localparam int CAPACITY = 251;
  localparam int KEY_BITS = 64;
  localparam int BKT_W = 16;
  localparam int MOD_BITS = 4;
  localparam int MOD_STEPS = 32 / MOD_BITS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_CONTAINS = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ_SLOT = 3'd4;

  localparam logic [31:0] FREED_HASH = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0] command;
    logic [63:0] raw_hash;
    logic [63:0] key;
    logic [7:0] slot_index;
  } req_t;

  typedef struct packed {
    logic hit;
    logic full_res;
    logic [63:0] slot_key;
    logic [7:0] live_count;
    logic [7:0] entry_count;
    logic [31:0] change_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0] command;
    logic [30:0] hash;
    logic [63:0] key;
    logic [7:0] slot_index;
    logic [BKT_W-1:0] bucket;
  } work_t;

endpackage

[hw/rtl/cshs_ram.sv]
module cshs_ram #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/cshs_fifo.sv]
module cshs_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

[hw/rtl/cshs_front.sv]
module cshs_front #(
  parameter int CAPACITY = cshs_pkg::CAPACITY
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  cshs_pkg::req_t  req,
  output logic            q_push,
  output cshs_pkg::work_t q_data,
  input  logic            q_full
);

  import cshs_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);

  logic busy;
  logic [3:0] cnt;
  logic [31:0] sh;
  logic [IW-1:0] rem;
  logic [IW-1:0] rem_next;
  logic [IW:0] t;
  work_t item;
  logic [30:0] fold;

  assign full = busy;
  assign fold = 31'(req.raw_hash[31:0] ^ req.raw_hash[63:32]);

  always_comb begin
    rem_next = rem;
    t = '0;
    for (int j = 0; j < MOD_BITS; j++) begin
      t = {rem_next, sh[31 - j]};
      if (t >= (IW+1)'(CAPACITY)) begin
        t = t - (IW+1)'(CAPACITY);
      end
      rem_next = t[IW-1:0];
    end
  end

  assign q_push = busy && (cnt == 4'(MOD_STEPS));
  always_comb begin
    q_data = item;
    q_data.bucket = BKT_W'(rem);
  end

  always_ff @(posedge clk) begin
    if (!busy && push) begin
      item.command <= req.command;
      item.hash <= fold;
      item.key <= req.key;
      item.slot_index <= req.slot_index;
      item.bucket <= '0;
      sh <= {1'b0, fold};
      rem <= '0;
      cnt <= '0;
    end else if (busy && cnt != 4'(MOD_STEPS)) begin
      sh <= sh << MOD_BITS;
      rem <= rem_next;
      cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy && push) begin
      busy <= 1'b1;
    end else if (q_push && !q_full) begin
      busy <= 1'b0;
    end
  end

endmodule

[hw/rtl/cshs_back.sv]
module cshs_back #(
  parameter int CAPACITY = cshs_pkg::CAPACITY,
  parameter int KEY_BITS = cshs_pkg::KEY_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  cshs_pkg::work_t q_data,
  output logic            q_pop,
  output logic            out_push,
  output cshs_pkg::rsp_t  out_data,
  input  logic            out_full
);

  import cshs_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [IW-1:0] NIL = {IW{1'b1}};
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HEAD = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_MISS = 4'd3;
  localparam logic [3:0] S_ALLOC = 4'd4;
  localparam logic [3:0] S_FOUND = 4'd5;
  localparam logic [3:0] S_REM2 = 4'd6;
  localparam logic [3:0] S_SLOT = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0] state, state_next;
  logic [2:0] cmd, cmd_next;
  logic [30:0] h, h_next;
  logic [KEY_BITS-1:0] k, k_next;
  logic [AW-1:0] bkt, bkt_next;
  logic hvld, hvld_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] prev, prev_next;
  logic [IW-1:0] steps, steps_next;
  logic [IW-1:0] head_val, head_val_next;
  logic [IW-1:0] link_e, link_e_next;
  logic [IW-1:0] used, used_next;
  logic [IW-1:0] freec, freec_next;
  logic [IW-1:0] fhead, fhead_next;
  logic [31:0] ver, ver_next;
  logic hit, hit_next;
  logic fullr, fullr_next;
  logic [KEY_BITS-1:0] skey, skey_next;
  logic [CAPACITY-1:0] head_vld, head_vld_next;

  logic hd_we;
  logic [AW-1:0] hd_waddr;
  logic [IW-1:0] hd_wdata;
  logic [IW-1:0] hd_rdata;
  logic [AW-1:0] er_addr;
  logic lk_we;
  logic [AW-1:0] lk_waddr;
  logic [IW-1:0] lk_wdata;
  logic [IW-1:0] lk_rdata;
  logic hs_we;
  logic [AW-1:0] hs_waddr;
  logic [31:0] hs_wdata;
  logic [31:0] hs_rdata;
  logic ky_we;
  logic [KEY_BITS-1:0] ky_rdata;
  logic ins_go;
  logic [IW-1:0] ins_e;
  logic [IW-1:0] cur0;
  logic [IW-1:0] steps_inc;
  logic match;

  cshs_ram #(.W(IW), .DEPTH(CAPACITY)) u_heads (
    .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(q_data.bucket[AW-1:0]), .rdata(hd_rdata)
  );

  cshs_ram #(.W(IW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(er_addr), .rdata(lk_rdata)
  );

  cshs_ram #(.W(32), .DEPTH(CAPACITY)) u_hash (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .raddr(er_addr), .rdata(hs_rdata)
  );

  cshs_ram #(.W(KEY_BITS), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(ky_we), .waddr(ins_e[AW-1:0]), .wdata(k),
    .raddr(er_addr), .rdata(ky_rdata)
  );

  assign cur0 = hvld ? hd_rdata : NIL;
  assign steps_inc = steps + IW'(1);
  assign match = (hs_rdata == {1'b0, h}) && (ky_rdata == k);

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    h_next = h;
    k_next = k;
    bkt_next = bkt;
    hvld_next = hvld;
    cur_next = cur;
    prev_next = prev;
    steps_next = steps;
    head_val_next = head_val;
    link_e_next = link_e;
    used_next = used;
    freec_next = freec;
    fhead_next = fhead;
    ver_next = ver;
    hit_next = hit;
    fullr_next = fullr;
    skey_next = skey;
    head_vld_next = head_vld;
    q_pop = 1'b0;
    out_push = 1'b0;
    hd_we = 1'b0;
    hd_waddr = bkt;
    hd_wdata = link_e;
    er_addr = '0;
    lk_we = 1'b0;
    lk_waddr = cur[AW-1:0];
    lk_wdata = fhead;
    hs_we = 1'b0;
    hs_waddr = cur[AW-1:0];
    hs_wdata = FREED_HASH;
    ky_we = 1'b0;
    ins_go = 1'b0;
    ins_e = used;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          cmd_next = q_data.command;
          h_next = q_data.hash;
          k_next = q_data.key[KEY_BITS-1:0];
          bkt_next = q_data.bucket[AW-1:0];
          hvld_next = head_vld[q_data.bucket[AW-1:0]];
          hit_next = 1'b0;
          fullr_next = 1'b0;
          skey_next = '0;
          if (q_data.command == CMD_CONTAINS || q_data.command == CMD_ADD ||
              q_data.command == CMD_REMOVE) begin
            state_next = S_HEAD;
          end else if (q_data.command == CMD_CLEAR) begin
            head_vld_next = '0;
            used_next = '0;
            freec_next = '0;
            fhead_next = NIL;
            ver_next = ver + 32'd1;
            state_next = S_RESP;
          end else if (q_data.command == CMD_READ_SLOT &&
                       32'(q_data.slot_index) < 32'(used) &&
                       32'(q_data.slot_index) < 32'(CAPACITY)) begin
            er_addr = AW'(q_data.slot_index);
            state_next = S_SLOT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_HEAD: begin
        head_val_next = cur0;
        cur_next = cur0;
        prev_next = NIL;
        steps_next = '0;
        if (cur0 < CAP_I) begin
          er_addr = cur0[AW-1:0];
          state_next = S_WALK;
        end else begin
          state_next = S_MISS;
        end
      end
      S_WALK: begin
        if (match) begin
          link_e_next = lk_rdata;
          state_next = S_FOUND;
        end else begin
          prev_next = cur;
          cur_next = lk_rdata;
          steps_next = steps_inc;
          if (lk_rdata < CAP_I && steps_inc < CAP_I) begin
            er_addr = lk_rdata[AW-1:0];
          end else begin
            state_next = S_MISS;
          end
        end
      end
      S_MISS: begin
        state_next = S_RESP;
        if (cmd == CMD_ADD) begin
          if (freec != '0 && fhead < CAP_I) begin
            er_addr = fhead[AW-1:0];
            state_next = S_ALLOC;
          end else if (used < CAP_I) begin
            ins_go = 1'b1;
            ins_e = used;
            used_next = used + IW'(1);
          end else begin
            fullr_next = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        ins_go = 1'b1;
        ins_e = fhead;
        fhead_next = lk_rdata;
        freec_next = freec - IW'(1);
        state_next = S_RESP;
      end
      S_FOUND: begin
        state_next = S_RESP;
        if (cmd == CMD_CONTAINS) begin
          hit_next = 1'b1;
        end else if (cmd == CMD_REMOVE) begin
          if (prev == NIL) begin
            hd_we = 1'b1;
            hd_wdata = link_e;
            head_vld_next[bkt] = 1'b1;
          end else begin
            lk_we = 1'b1;
            lk_waddr = prev[AW-1:0];
            lk_wdata = link_e;
          end
          hs_we = 1'b1;
          state_next = S_REM2;
        end
      end
      S_REM2: begin
        lk_we = 1'b1;
        fhead_next = cur;
        freec_next = freec + IW'(1);
        ver_next = ver + 32'd1;
        hit_next = 1'b1;
        state_next = S_RESP;
      end
      S_SLOT: begin
        if (hs_rdata != FREED_HASH) begin
          hit_next = 1'b1;
          skey_next = ky_rdata;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_full) begin
          out_push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (ins_go) begin
      hs_we = 1'b1;
      hs_waddr = ins_e[AW-1:0];
      hs_wdata = {1'b0, h};
      ky_we = 1'b1;
      lk_we = 1'b1;
      lk_waddr = ins_e[AW-1:0];
      lk_wdata = head_val;
      hd_we = 1'b1;
      hd_wdata = ins_e;
      head_vld_next[bkt] = 1'b1;
      ver_next = ver + 32'd1;
      hit_next = 1'b1;
    end
  end

  always_comb begin
    out_data.hit = hit;
    out_data.full_res = fullr;
    out_data.slot_key = 64'(skey);
    out_data.live_count = 8'(used - freec);
    out_data.entry_count = 8'(used);
    out_data.change_count = ver;
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    h <= h_next;
    k <= k_next;
    bkt <= bkt_next;
    hvld <= hvld_next;
    cur <= cur_next;
    prev <= prev_next;
    steps <= steps_next;
    head_val <= head_val_next;
    link_e <= link_e_next;
    hit <= hit_next;
    fullr <= fullr_next;
    skey <= skey_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      freec <= '0;
      fhead <= NIL;
      ver <= '0;
      head_vld <= '0;
    end else begin
      state <= state_next;
      used <= used_next;
      freec <= freec_next;
      fhead <= fhead_next;
      ver <= ver_next;
      head_vld <= head_vld_next;
    end
  end

  a_free_le_used: assert property (@(posedge clk) disable iff (rst) freec <= used)
    else $error("free count exceeds used count");
  a_used_le_cap: assert property (@(posedge clk) disable iff (rst) used <= CAP_I)
    else $error("used count beyond capacity");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> steps < CAP_I && cur < CAP_I)
    else $error("chain walk out of bounds");
  a_free_head: assert property (@(posedge clk) disable iff (rst)
    freec == '0 |-> fhead == NIL || $past(state) == S_REM2 || state != S_IDLE)
    else $error("free list head without free entries");

endmodule

[hw/rtl/chained_hash_set_engine_unit.sv]
// channel | dir | handshake                   | payload
// req     | in  | push / full, beat on push&!full | command, raw_hash, key, slot_index
// rsp     | out | empty / pop, beat on pop&!empty | hit, full_res, slot_key, counts
//
// Front: accepts an item, reduces its folded hash modulo CAPACITY 4 bits a cycle, then
// hands it off to the queue; it takes no new request until the queue has taken the last.
// Back: pops the item, reads the bucket head, then walks the chain link by link through
// the entry memories to a miss or a match; an add from the free list adds an allocate
// state and a remove a second remove state. Clear and slot read do not walk the chain.
// Reset clears counts, free list and all bucket head valid bits.
// A two-beat queue parts front and back, and a two-beat queue holds results, so
// a stalled pop holds the back end without blocking intake until both queues fill.
module chained_hash_set_engine_unit #(
  parameter int CAPACITY = cshs_pkg::CAPACITY,
  parameter int KEY_BITS = cshs_pkg::KEY_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  cshs_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output cshs_pkg::rsp_t rsp
);

  import cshs_pkg::*;

  logic q_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  work_t f_data;
  work_t b_data;
  logic [$bits(work_t)-1:0] q_rdata;
  logic out_push;
  logic out_full;
  rsp_t out_data;
  logic [$bits(rsp_t)-1:0] o_rdata;

  cshs_front #(.CAPACITY(CAPACITY)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .q_push(q_push), .q_data(f_data), .q_full(q_full)
  );

  cshs_fifo #(.W($bits(work_t)), .DEPTH(QUEUE_DEPTH)) u_work_q (
    .clk(clk), .rst(rst), .push(q_push), .wdata(f_data), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  assign b_data = q_rdata;

  cshs_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(b_data), .q_pop(q_pop),
    .out_push(out_push), .out_data(out_data), .out_full(out_full)
  );

  cshs_fifo #(.W($bits(rsp_t)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
    .clk(clk), .rst(rst), .push(out_push), .wdata(out_data), .full(out_full),
    .pop(pop), .rdata(o_rdata), .empty(empty)
  );

  assign rsp = o_rdata;

endmodule

[dv/tb_chained_hash_set_engine_unit.sv]
`timescale 1ns / 100ps

module tb_chained_hash_set_engine_unit;
  import cshs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [8:0] NO_ENTRY = 9'h1FF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;

  chained_hash_set_engine_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req(req), .empty(empty), .pop(pop), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // set state
  logic [8:0] heads [CAPACITY];
  logic [8:0] links [CAPACITY];
  logic [31:0] hashes [CAPACITY];
  logic [63:0] keys [CAPACITY];
  int unsigned used_n, free_n, version_n;
  logic [8:0] free_top;

  rsp_t expected_rsp [$];
  int errors = 0;
  int beats_in = 0, beats_out = 0, hits_seen = 0, fulls_seen = 0;
  int idle_pct = 20;
  int idle_cnt = 0;
  logic done = 1'b0;

  logic [63:0] key_pool [16];
  logic [63:0] hash_pool [16];

  function automatic logic [30:0] fold(input logic [63:0] raw);
    return 31'(raw[31:0] ^ raw[63:32]);
  endfunction

  function automatic logic [8:0] chain_find(input int b, input logic [31:0] h,
                                            input logic [63:0] k,
                                            output logic [8:0] prev);
    logic [8:0] i;
    logic [8:0] last;
    int steps;
    i = heads[b];
    last = NO_ENTRY;
    steps = 0;
    prev = NO_ENTRY;
    while (i < CAPACITY && steps < CAPACITY) begin
      if (hashes[i] == h && keys[i] == k) begin
        prev = last;
        return i;
      end
      last = i;
      i = links[i];
      steps++;
    end
    return NO_ENTRY;
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    logic [31:0] h;
    int b;
    logic [8:0] e, prev;
    o = '0;
    h = {1'b0, fold(r.raw_hash)};
    b = h % CAPACITY;
    case (r.command)
      CMD_CONTAINS: o.hit = chain_find(b, h, r.key, prev) != NO_ENTRY;
      CMD_ADD: begin
        if (chain_find(b, h, r.key, prev) == NO_ENTRY) begin
          e = NO_ENTRY;
          if (free_n > 0 && free_top < CAPACITY) begin
            e = free_top;
            free_top = links[e];
            free_n--;
          end else if (used_n < CAPACITY) begin
            e = used_n[8:0];
            used_n++;
          end else begin
            o.full_res = 1'b1;
          end
          if (e != NO_ENTRY) begin
            hashes[e] = h;
            keys[e] = r.key;
            links[e] = heads[b];
            heads[b] = e;
            version_n++;
            o.hit = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        e = chain_find(b, h, r.key, prev);
        if (e != NO_ENTRY) begin
          if (prev == NO_ENTRY) heads[b] = links[e];
          else links[prev] = links[e];
          hashes[e] = FREED_HASH;
          keys[e] = '0;
          links[e] = free_top;
          free_top = e;
          free_n++;
          version_n++;
          o.hit = 1'b1;
        end
      end
      CMD_CLEAR: begin
        foreach (heads[i]) heads[i] = NO_ENTRY;
        used_n = 0;
        free_n = 0;
        free_top = NO_ENTRY;
        version_n++;
      end
      CMD_READ_SLOT: begin
        if (r.slot_index < used_n && r.slot_index < CAPACITY &&
            hashes[r.slot_index] != FREED_HASH) begin
          o.hit = 1'b1;
          o.slot_key = keys[r.slot_index];
        end
      end
      default: ;
    endcase
    o.live_count = 8'(used_n - free_n);
    o.entry_count = 8'(used_n);
    o.change_count = version_n;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch beat %0d %s: got %0h want %0h", beats_out, what, got, want);
    errors++;
  endtask

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_rsp.push_back(apply_request(r));
    beats_in++;
    @(negedge clk);
  endtask

  function automatic req_t make_req(input logic [2:0] c, input logic [63:0] h,
                                    input logic [63:0] k, input logic [7:0] s);
    req_t r;
    r.command = c;
    r.raw_hash = h;
    r.key = k;
    r.slot_index = s;
    return r;
  endfunction

  always @(negedge clk) pop <= !rst && ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    rsp_t w;
    if (!rst && pop && !empty) begin
      beats_out++;
      if (expected_rsp.size() == 0) begin
        $display("unexpected result beat %0d", beats_out);
        errors++;
      end else begin
        w = expected_rsp.pop_front();
        if (rsp.hit) hits_seen++;
        if (rsp.full_res) fulls_seen++;
        if (rsp.hit !== w.hit) report_mismatch("hit", 64'(rsp.hit), 64'(w.hit));
        if (rsp.full_res !== w.full_res)
          report_mismatch("full_res", 64'(rsp.full_res), 64'(w.full_res));
        if (rsp.slot_key !== w.slot_key) report_mismatch("slot_key", rsp.slot_key, w.slot_key);
        if (rsp.live_count !== w.live_count)
          report_mismatch("live_count", 64'(rsp.live_count), 64'(w.live_count));
        if (rsp.entry_count !== w.entry_count)
          report_mismatch("entry_count", 64'(rsp.entry_count), 64'(w.entry_count));
        if (rsp.change_count !== w.change_count)
          report_mismatch("change_count", 64'(rsp.change_count), 64'(w.change_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (push && !full) || (pop && !empty)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_rsp.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    send_request(make_req(CMD_CONTAINS, '0, '0, 8'd0));
    send_request(make_req(CMD_READ_SLOT, '0, '0, 8'd0));
    send_request(make_req(CMD_ADD, '0, '0, 8'd0));
    send_request(make_req(CMD_ADD, '0, '0, 8'd0));
    send_request(make_req(CMD_ADD, '1, '1, 8'hFF));
    send_request(make_req(CMD_ADD, 64'h0000_0000_8000_0000, 64'h55, 8'd0));
    send_request(make_req(CMD_ADD, 64'h0000_00FB_0000_0000, 64'hAA, 8'd0));
    send_request(make_req(CMD_CONTAINS, 64'h0000_00FB_0000_0000, 64'hAA, 8'd0));
    send_request(make_req(CMD_CONTAINS, 64'h0000_00FB_0000_0000, 64'hAB, 8'd0));
    send_request(make_req(CMD_READ_SLOT, '0, '0, 8'd1));
    send_request(make_req(CMD_READ_SLOT, '0, '0, 8'd250));
    send_request(make_req(CMD_READ_SLOT, '0, '0, 8'hFF));
    send_request(make_req(CMD_REMOVE, '0, '0, 8'd0));
    send_request(make_req(CMD_REMOVE, '0, '0, 8'd0));
    send_request(make_req(CMD_READ_SLOT, '0, '0, 8'd0));
    send_request(make_req(CMD_ADD, 64'd7, 64'd7, 8'd0));
    send_request(make_req(3'd5, '1, '1, 8'hFF));
    send_request(make_req(3'd6, '0, '0, 8'd0));
    send_request(make_req(3'd7, '1, '0, 8'd0));
    send_request(make_req(CMD_CLEAR, '1, '1, 8'hFF));
    send_request(make_req(CMD_CONTAINS, 64'd7, 64'd7, 8'd0));
  endtask

  task automatic test_fill_store();
    // overflow the store, read back random slots, then clear it
    for (int i = 0; i < CAPACITY + 4; i++)
      send_request(make_req(CMD_ADD, rand64(), rand64(), 8'd0));
    for (int i = 0; i < 8; i++)
      send_request(make_req(CMD_READ_SLOT, '0, '0, 8'($urandom_range(255))));
    send_request(make_req(CMD_CLEAR, '0, '0, 8'd0));
  endtask

  task automatic test_random_mix(input int n);
    int sel, p;
    logic [2:0] c;
    foreach (key_pool[i]) begin
      key_pool[i] = rand64();
      // collide some buckets
      hash_pool[i] = (i < 8) ? 64'(i * CAPACITY) : rand64();
    end
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      p = $urandom_range(15);
      if (sel < 30) c = CMD_ADD;
      else if (sel < 55) c = CMD_CONTAINS;
      else if (sel < 78) c = CMD_REMOVE;
      else if (sel < 95) c = CMD_READ_SLOT;
      else if (sel < 97) c = CMD_CLEAR;
      else c = 3'($urandom_range(7));
      if ($urandom_range(9) == 0)
        send_request(make_req(c, rand64(), rand64(), 8'($urandom_range(255))));
      else
        send_request(make_req(c, hash_pool[p], key_pool[p], 8'($urandom_range(20))));
    end
  endtask

  initial begin
    foreach (heads[i]) heads[i] = NO_ENTRY;
    used_n = 0;
    free_n = 0;
    free_top = NO_ENTRY;
    version_n = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_store();
    test_random_mix(400);
    idle_pct = 0;
    test_random_mix(300);
    idle_pct = 20;
    test_random_mix(400);
    push <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    done = 1'b1;
    repeat (40) @(posedge clk);
    $display("sent %0d requests, checked %0d results", beats_in, beats_out);
    $display("hits %0d, store-full refusals %0d", hits_seen, fulls_seen);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cshs_pkg.sv
hw/rtl/cshs_ram.sv
hw/rtl/cshs_fifo.sv
hw/rtl/cshs_front.sv
hw/rtl/cshs_back.sv
hw/rtl/chained_hash_set_engine_unit.sv
dv/tb_chained_hash_set_engine_unit.sv
